// File: rtl/core/hdne_pkg.sv
// Package of the histogram delta nibble encoder.
// Holds the queue entry type, class masks and class helpers; no dependencies.
package hdne_pkg;

   localparam int unsigned WordW  = 32;
   localparam int unsigned CountW = 21;
   localparam int unsigned StreamW = 72;

   localparam logic [WordW-1:0] Class1Mask = 32'hffff_fff8;
   localparam logic [WordW-1:0] Class2Mask = 32'hffff_ff80;
   localparam logic [WordW-1:0] Class3Mask = 32'hffff_8000;

   localparam logic [1:0] ClassOneNib   = 2'd0;
   localparam logic [1:0] ClassTwoNib   = 2'd1;
   localparam logic [1:0] ClassFourNib  = 2'd2;
   localparam logic [1:0] ClassEightNib = 2'd3;

   localparam logic KindData = 1'b0;
   localparam logic KindCode = 1'b1;

   typedef struct packed {
      logic [WordW-1:0]  hess_delta;
      logic [WordW-1:0]  grad_delta;
      logic [1:0]        hess_class;
      logic [1:0]        grad_class;
      logic              pend_flag;
      logic [3:0]        pend_nib;
      logic              last_bin;
      logic [7:0]        code_byte;
      logic              code_due;
      logic [CountW-1:0] total;
   } entry_type;

   function automatic logic [1:0] class_of(input logic [WordW-1:0] d);
      logic [WordW-1:0] f;
      f = d[WordW-1] ? ~d : d;
      class_of = 2'((|(f & Class1Mask))) + 2'((|(f & Class2Mask)))
               + 2'((|(f & Class3Mask)));
   endfunction

   function automatic logic [3:0] nib_count(input logic [1:0] c);
      case (c)
         ClassOneNib:  nib_count = 4'd1;
         ClassTwoNib:  nib_count = 4'd2;
         ClassFourNib: nib_count = 4'd4;
         default:      nib_count = 4'd8;
      endcase
   endfunction

   function automatic logic [WordW-1:0] keep_nibs(input logic [WordW-1:0] d,
                                                  input logic [1:0] c);
      case (c)
         ClassOneNib:  keep_nibs = {28'd0, d[3:0]};
         ClassTwoNib:  keep_nibs = {24'd0, d[7:0]};
         ClassFourNib: keep_nibs = {16'd0, d[15:0]};
         default:      keep_nibs = d;
      endcase
   endfunction

   function automatic logic [3:0] top_nib(input logic [WordW-1:0] d,
                                          input logic [1:0] c);
      case (c)
         ClassOneNib:  top_nib = d[3:0];
         ClassTwoNib:  top_nib = d[7:4];
         ClassFourNib: top_nib = d[15:12];
         default:      top_nib = d[31:28];
      endcase
   endfunction

endpackage

// File: rtl/core/hdne_if.sv
// Channel interfaces of the histogram delta nibble encoder.
// Bin input, byte output and mode register write; no dependencies.
interface hdne_req_if;
   logic               valid;
   logic               ready;
   logic [31:0]        hess;
   logic signed [31:0] grad;
   logic               last_bin;
   modport source (output valid, hess, grad, last_bin, input ready);
   modport sink (input valid, hess, grad, last_bin, output ready);
endinterface

interface hdne_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  out_byte;
   logic        byte_kind;
   logic        last;
   logic [20:0] nibble_total;
   modport source (output valid, out_byte, byte_kind, last, nibble_total, input ready);
   modport sink (input valid, out_byte, byte_kind, last, nibble_total, output ready);
endinterface

interface hdne_csr_if;
   logic valid;
   logic ready;
   logic narrow_mode;
   modport source (output valid, narrow_mode, input ready);
   modport sink (input valid, narrow_mode, output ready);
endinterface

// File: rtl/core/hdne_front.sv
// Front end: takes bins, forms differences and classes, keeps the coder state.
// Depends on hdne_pkg and hdne_if.
module hdne_front (
   input  logic               clock,
   input  logic               reset,
   hdne_req_if.sink           req_chan,
   hdne_csr_if.sink           csr_chan,
   input  logic               q_ready,
   output logic               q_write,
   output hdne_pkg::entry_type q_entry
);
   import hdne_pkg::*;

   logic              narrow_ff, narrow_in;
   logic [WordW-1:0]  last_hess_ff, last_hess_in;
   logic [WordW-1:0]  last_grad_ff, last_grad_in;
   logic              pend_flag_ff, pend_flag_in;
   logic [3:0]        pend_nib_ff, pend_nib_in;
   logic [7:0]        code_acc_ff, code_acc_in;
   logic              parity_ff, parity_in;
   logic [CountW-1:0] count_ff, count_in;

   logic [WordW-1:0]  hess_v, grad_v, hess_delta, grad_delta;
   logic [1:0]        hess_class, grad_class;
   logic [7:0]        code_byte;
   logic              odd_total;
   logic [CountW:0]   count_sum;
   logic [CountW-1:0] total;

   assign csr_chan.ready = 1'b1;
   assign req_chan.ready = q_ready;
   assign q_write        = req_chan.valid & q_ready;

   always_comb begin
      hess_v = narrow_ff ? {16'd0, req_chan.hess[15:0]} : req_chan.hess;
      grad_v = narrow_ff ? {{16{req_chan.grad[15]}}, req_chan.grad[15:0]}
                         : req_chan.grad;
      hess_delta = hess_v - last_hess_ff;
      grad_delta = grad_v - last_grad_ff;
      hess_class = class_of(hess_delta);
      grad_class = class_of(grad_delta);
      code_byte  = code_acc_ff | (parity_ff ? {grad_class, hess_class, 4'd0}
                                            : {4'd0, grad_class, hess_class});
      odd_total  = pend_flag_ff ^ (hess_class == ClassOneNib) ^ (grad_class == ClassOneNib);
      count_sum  = {1'b0, count_ff} + (CountW+1)'(nib_count(hess_class))
                 + (CountW+1)'(nib_count(grad_class));
      total      = count_sum[CountW] ? '1 : count_sum[CountW-1:0];
   end

   always_comb begin
      q_entry.hess_delta = hess_delta;
      q_entry.grad_delta = grad_delta;
      q_entry.hess_class = hess_class;
      q_entry.grad_class = grad_class;
      q_entry.pend_flag  = pend_flag_ff;
      q_entry.pend_nib   = pend_nib_ff;
      q_entry.last_bin   = req_chan.last_bin;
      q_entry.code_byte  = code_byte;
      q_entry.code_due   = parity_ff | req_chan.last_bin;
      q_entry.total      = total;
   end

   always_comb begin
      narrow_in    = narrow_ff;
      last_hess_in = last_hess_ff;
      last_grad_in = last_grad_ff;
      pend_flag_in = pend_flag_ff;
      pend_nib_in  = pend_nib_ff;
      code_acc_in  = code_acc_ff;
      parity_in    = parity_ff;
      count_in     = count_ff;
      if (csr_chan.valid) begin
         narrow_in = csr_chan.narrow_mode;
      end
      if (q_write) begin
         if (req_chan.last_bin) begin
            last_hess_in = '0;
            last_grad_in = '0;
            pend_flag_in = 1'b0;
            pend_nib_in  = '0;
            code_acc_in  = '0;
            parity_in    = 1'b0;
            count_in     = '0;
         end else begin
            last_hess_in = hess_v;
            last_grad_in = grad_v;
            pend_flag_in = odd_total;
            pend_nib_in  = odd_total ? top_nib(grad_delta, grad_class) : 4'd0;
            code_acc_in  = parity_ff ? 8'd0 : code_byte;
            parity_in    = ~parity_ff;
            count_in     = total;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         narrow_ff    <= 1'b0;
         last_hess_ff <= '0;
         last_grad_ff <= '0;
         pend_flag_ff <= 1'b0;
         pend_nib_ff  <= '0;
         code_acc_ff  <= '0;
         parity_ff    <= 1'b0;
         count_ff     <= '0;
      end else begin
         narrow_ff    <= narrow_in;
         last_hess_ff <= last_hess_in;
         last_grad_ff <= last_grad_in;
         pend_flag_ff <= pend_flag_in;
         pend_nib_ff  <= pend_nib_in;
         code_acc_ff  <= code_acc_in;
         parity_ff    <= parity_in;
         count_ff     <= count_in;
      end
   end

endmodule

// File: rtl/core/hdne_queue.sv
// Bin queue between front and back end of the encoder.
// Depends on hdne_pkg.
module hdne_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                wr_en,
   input  hdne_pkg::entry_type wr_data,
   output logic                wr_ready,
   input  logic                rd_en,
   output logic                rd_valid,
   output hdne_pkg::entry_type rd_data
);
   import hdne_pkg::*;

   localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CntW = $clog2(DEPTH + 1);

   entry_type           entry_ff [DEPTH];
   logic [PtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]     count_ff, count_in;
   logic                do_wr, do_rd;

   assign wr_ready = (count_ff != CntW'(DEPTH));
   assign rd_valid = (count_ff != '0);
   assign rd_data  = entry_ff[rd_ptr_ff];
   assign do_wr    = wr_en & wr_ready;
   assign do_rd    = rd_en & rd_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: rtl/core/hdne_back.sv
// Back end: unpacks one queued bin into data and code words, one word a cycle unless the output stalls.
// Depends on hdne_pkg and hdne_if.
module hdne_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  hdne_pkg::entry_type q_entry,
   output logic                q_read,
   hdne_rsp_if.source          rsp_chan
);
   import hdne_pkg::*;

   logic [StreamW-1:0] stream_ff, stream_in;
   logic [3:0]         data_left_ff, data_left_in;
   logic               code_due_ff, code_due_in;
   logic [7:0]         code_byte_ff, code_byte_in;
   logic               last_ff, last_in;
   logic [CountW-1:0]  total_ff, total_in;

   logic               out_valid_ff, out_valid_in;
   logic [7:0]         out_byte_ff, out_byte_in;
   logic               out_kind_ff, out_kind_in;
   logic               out_last_ff, out_last_in;
   logic [CountW-1:0]  out_total_ff, out_total_in;

   logic               active, out_free, emit, still;
   logic [3:0]         left_after;
   logic               due_after;
   logic [WordW-1:0]   hess_keep, grad_keep;
   logic [35:0]        base;
   logic [3:0]         grad_off;
   logic [4:0]         nib_total;
   logic [StreamW-1:0] load_stream;
   logic [3:0]         load_bytes;

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.out_byte     = out_byte_ff;
   assign rsp_chan.byte_kind    = out_kind_ff;
   assign rsp_chan.last         = out_last_ff;
   assign rsp_chan.nibble_total = out_total_ff;

   always_comb begin
      hess_keep   = keep_nibs(q_entry.hess_delta, q_entry.hess_class);
      grad_keep   = keep_nibs(q_entry.grad_delta, q_entry.grad_class);
      base        = q_entry.pend_flag ? {hess_keep, q_entry.pend_nib} : {4'd0, hess_keep};
      grad_off    = 4'(q_entry.pend_flag) + nib_count(q_entry.hess_class);
      load_stream = {36'd0, base}
                  | ({40'd0, grad_keep} << {grad_off, 2'b00});
      nib_total   = 5'(grad_off) + 5'(nib_count(q_entry.grad_class));
      load_bytes  = q_entry.last_bin ? 4'((nib_total + 5'd1) >> 1) : 4'(nib_total >> 1);
   end

   always_comb begin
      active     = (data_left_ff != '0) | code_due_ff;
      out_free   = ~out_valid_ff | rsp_chan.ready;
      emit       = active & out_free;
      left_after = data_left_ff - 4'(emit && (data_left_ff != '0));
      due_after  = code_due_ff & ~(emit && (data_left_ff == '0));
      still      = (left_after != '0) | due_after;
      q_read     = q_valid & ~still;
   end

   always_comb begin
      stream_in    = stream_ff;
      data_left_in = left_after;
      code_due_in  = due_after;
      code_byte_in = code_byte_ff;
      last_in      = last_ff;
      total_in     = total_ff;
      if (q_read) begin
         stream_in    = load_stream;
         data_left_in = load_bytes;
         code_due_in  = q_entry.code_due;
         code_byte_in = q_entry.code_byte;
         last_in      = q_entry.last_bin;
         total_in     = q_entry.total;
      end else if (emit && (data_left_ff != '0)) begin
         stream_in = stream_ff >> 8;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff & ~rsp_chan.ready;
      out_byte_in  = out_byte_ff;
      out_kind_in  = out_kind_ff;
      out_last_in  = out_last_ff;
      out_total_in = out_total_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         out_total_in = total_ff;
         if (data_left_ff != '0) begin
            out_byte_in = stream_ff[7:0];
            out_kind_in = KindData;
            out_last_in = 1'b0;
         end else begin
            out_byte_in = code_byte_ff;
            out_kind_in = KindCode;
            out_last_in = last_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      stream_ff    <= stream_in;
      code_byte_ff <= code_byte_in;
      last_ff      <= last_in;
      total_ff     <= total_in;
      out_byte_ff  <= out_byte_in;
      out_kind_ff  <= out_kind_in;
      out_last_ff  <= out_last_in;
      out_total_ff <= out_total_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_left_ff <= '0;
         code_due_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         data_left_ff <= data_left_in;
         code_due_ff  <= code_due_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

// File: rtl/core/histogram_delta_nibble_encoder.sv
// Histogram delta nibble encoder, top level.
// A bin is written into the queue, then loaded into the back end, then registered out.
// Throughput: one word a cycle from the back end while the output is taken; a bin
// yields one to ten words (nine data words and a code word at most).
// Reset: synchronous, clears coder state, queue and output; narrow mode returns to 0.
// Depends on hdne_pkg, hdne_if, hdne_front, hdne_queue and hdne_back.
module histogram_delta_nibble_encoder #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   hdne_req_if.sink   req_chan,
   hdne_rsp_if.source rsp_chan,
   hdne_csr_if.sink   csr_chan
);
   import hdne_pkg::*;

   entry_type wr_entry, rd_entry;
   logic      q_write, q_ready, q_valid, q_read;

   hdne_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .csr_chan (csr_chan),
      .q_ready  (q_ready),
      .q_write  (q_write),
      .q_entry  (wr_entry)
   );

   hdne_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (q_write),
      .wr_data  (wr_entry),
      .wr_ready (q_ready),
      .rd_en    (q_read),
      .rd_valid (q_valid),
      .rd_data  (rd_entry)
   );

   hdne_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (q_valid),
      .q_entry  (rd_entry),
      .q_read   (q_read),
      .rsp_chan (rsp_chan)
   );

endmodule
